// ----- rtl/c8dfr_pkg.sv -----
// Shared types, constants and the CRC-8 byte update for the frame deframer.
// No dependencies; used by every module of the block but the RAM.
`default_nettype none

package c8dfr_pkg;

  localparam int unsigned LEN_W = 6;

  localparam logic [7:0] START_BYTE = 8'hAA;
  localparam logic [7:0] END_BYTE   = 8'h55;
  localparam logic [7:0] CRC_POLY   = 8'h07;
  localparam logic [7:0] CRC_MSB    = 8'h80;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 6'd62;

  // register decode: paddr[2] selects the register word
  localparam logic REG_MAX_LEN = 1'b0;

  // frame descriptor handed from front to back
  typedef struct packed {
    logic [7:0]       command;
    logic [LEN_W-1:0] payload_len;
    logic             bank;
  } desc_t;

  // MSB-first CRC-8 update, no reflection
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 8'h00) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/c8dfr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module c8dfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/c8dfr_front.sv -----
// Receive-side parser: hunts for frames, checks length and CRC, stores payload
// bytes into the current buffer bank and pushes a descriptor per good frame.
// Depends on c8dfr_pkg.
`default_nettype none

module c8dfr_front #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  input  wire logic [7:0]                          in_rx_byte,
  output      logic                                in_stall,
  input  wire logic [c8dfr_pkg::LEN_W-1:0]         max_len,
  input  wire logic                                q_full,
  output      logic                                push,
  output      c8dfr_pkg::desc_t                    push_desc,
  output      logic                                we,
  output      logic [$clog2(BUFFER_DEPTH):0]       waddr,
  output      logic [7:0]                          wdata
);

  localparam int unsigned IW = $clog2(BUFFER_DEPTH);
  localparam logic [16:0] DEPTH_LIM = 17'(BUFFER_DEPTH + 1);

  typedef enum logic [6:0] {
    PH_HUNT   = 7'b0000001,
    PH_LEN_LO = 7'b0000010,
    PH_LEN_HI = 7'b0000100,
    PH_CMD    = 7'b0001000,
    PH_DATA   = 7'b0010000,
    PH_CRC    = 7'b0100000,
    PH_END    = 7'b1000000
  } phase_t;

  phase_t                      phase_r, phase_nxt;
  logic [7:0]                  len_lo_r, len_lo_nxt;
  logic [c8dfr_pkg::LEN_W-1:0] rem_r, rem_nxt;
  logic [c8dfr_pkg::LEN_W-1:0] flen_r, flen_nxt;
  logic [7:0]                  cmd_r, cmd_nxt;
  logic [7:0]                  crc_r, crc_nxt;
  logic                        match_r, match_nxt;
  logic                        bank_r, bank_nxt;

  logic                        accept;
  logic [15:0]                 len16;
  logic                        len_bad;
  logic [c8dfr_pkg::LEN_W-1:0] wr_idx;

  // stall only where a bank or a queue slot is needed
  assign in_stall = q_full && (phase_r == PH_DATA || phase_r == PH_END);
  assign accept   = in_valid && !in_stall;

  assign len16   = {in_rx_byte, len_lo_r};
  assign len_bad = (len16 == 16'd0) || (len16 > {10'd0, max_len}) || ({1'b0, len16} > DEPTH_LIM);

  assign wr_idx = flen_r - rem_r;
  assign waddr  = {bank_r, IW'(wr_idx)};
  assign wdata  = in_rx_byte;

  assign push_desc = '{command: cmd_r, payload_len: flen_r, bank: bank_r};

  always_comb begin
    phase_nxt  = phase_r;
    len_lo_nxt = len_lo_r;
    rem_nxt    = rem_r;
    flen_nxt   = flen_r;
    cmd_nxt    = cmd_r;
    crc_nxt    = crc_r;
    match_nxt  = match_r;
    bank_nxt   = bank_r;
    push       = 1'b0;
    we         = 1'b0;
    if (accept) begin
      case (phase_r)
        PH_LEN_LO: begin
          len_lo_nxt = in_rx_byte;
          phase_nxt  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          if (len_bad) begin
            phase_nxt = PH_HUNT;
          end else begin
            flen_nxt  = c8dfr_pkg::LEN_W'(len16 - 16'd1);
            rem_nxt   = c8dfr_pkg::LEN_W'(len16 - 16'd1);
            phase_nxt = PH_CMD;
          end
        end
        PH_CMD: begin
          cmd_nxt   = in_rx_byte;
          crc_nxt   = c8dfr_pkg::crc8_byte(8'h00, in_rx_byte);
          phase_nxt = (rem_r == '0) ? PH_CRC : PH_DATA;
        end
        PH_DATA: begin
          we      = 1'b1;
          crc_nxt = c8dfr_pkg::crc8_byte(crc_r, in_rx_byte);
          rem_nxt = rem_r - 1'b1;
          if (rem_nxt == '0) begin
            phase_nxt = PH_CRC;
          end
        end
        PH_CRC: begin
          match_nxt = (in_rx_byte == crc_r);
          phase_nxt = PH_END;
        end
        PH_END: begin
          phase_nxt = PH_HUNT;
          if (in_rx_byte == c8dfr_pkg::END_BYTE && match_r) begin
            push     = 1'b1;
            bank_nxt = !bank_r;
          end
          match_nxt = 1'b0;
        end
        default: begin
          // hunting, and any stray code
          phase_nxt = (in_rx_byte == c8dfr_pkg::START_BYTE) ? PH_LEN_LO : PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      len_lo_r <= '0;
      rem_r    <= '0;
      flen_r   <= '0;
      cmd_r    <= '0;
      crc_r    <= '0;
      match_r  <= 1'b0;
      bank_r   <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      len_lo_r <= len_lo_nxt;
      rem_r    <= rem_nxt;
      flen_r   <= flen_nxt;
      cmd_r    <= cmd_nxt;
      crc_r    <= crc_nxt;
      match_r  <= match_nxt;
      bank_r   <= bank_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/c8dfr_queue.sv -----
// Two-entry descriptor queue between parser and emitter, one entry per bank.
// Depends on c8dfr_pkg.
`default_nettype none

module c8dfr_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire c8dfr_pkg::desc_t push_desc,
  input  wire logic             pop,
  output      c8dfr_pkg::desc_t head,
  output      logic             empty,
  output      logic             full
);

  c8dfr_pkg::desc_t ent_r [2];
  logic             wptr_r, wptr_nxt;
  logic             rptr_r, rptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  assign head  = ent_r[rptr_r];
  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);

  always_comb begin
    wptr_nxt = push ? !wptr_r : wptr_r;
    rptr_nxt = pop ? !rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/c8dfr_back.sv -----
// Emitter: walks the head frame's payload bank, one result per cycle unless
// stalled, frees the descriptor on its last result. Depends on c8dfr_pkg.
`default_nettype none

module c8dfr_back #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire c8dfr_pkg::desc_t               head,
  input  wire logic                           q_empty,
  output      logic                           pop,
  output      logic                           re,
  output      logic [$clog2(BUFFER_DEPTH):0]  raddr,
  input  wire logic [7:0]                     rdata,
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      logic [7:0]                     out_command,
  output      logic [7:0]                     out_payload_byte,
  output      logic [c8dfr_pkg::LEN_W-1:0]    out_payload_length,
  output      logic                           out_has_payload,
  output      logic                           out_last
);

  localparam int unsigned IW = $clog2(BUFFER_DEPTH);

  logic                        out_valid_r, out_valid_nxt;
  logic [c8dfr_pkg::LEN_W-1:0] idx_r, idx_nxt;
  logic [7:0]                  cmd_r, cmd_nxt;
  logic [c8dfr_pkg::LEN_W-1:0] len_r, len_nxt;
  logic                        has_r, has_nxt;
  logic                        last_r, last_nxt;

  logic adv;
  logic issue_last;

  // output slot free or being taken this cycle
  assign adv        = !out_valid_r || !out_stall;
  assign re         = adv && !q_empty;
  assign raddr      = {head.bank, IW'(idx_r)};
  assign issue_last = (head.payload_len == '0) ||
                      (({1'b0, idx_r} + 7'd1) == {1'b0, head.payload_len});
  assign pop        = re && issue_last;

  always_comb begin
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    cmd_nxt       = cmd_r;
    len_nxt       = len_r;
    has_nxt       = has_r;
    last_nxt      = last_r;
    if (adv) begin
      out_valid_nxt = !q_empty;
      if (!q_empty) begin
        cmd_nxt  = head.command;
        len_nxt  = head.payload_len;
        has_nxt  = (head.payload_len != '0);
        last_nxt = issue_last;
        idx_nxt  = issue_last ? '0 : idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    len_r  <= len_nxt;
    has_r  <= has_nxt;
    last_r <= last_nxt;
  end

  // RAM read register holds while stalled since no read is issued then
  assign out_valid          = out_valid_r;
  assign out_command        = cmd_r;
  assign out_payload_byte   = has_r ? rdata : 8'h00;
  assign out_payload_length = len_r;
  assign out_has_payload    = has_r;
  assign out_last           = last_r;

endmodule

`default_nettype wire

// ----- rtl/crc8_frame_deframer.sv -----
// Frame deframer: STX, LE length, command, payload, CRC-8, ETX.
// Input: one byte per cycle; stalls only when both payload banks hold frames not yet emitted.
// Output: one result per cycle unless stalled; ETX queues a descriptor, then results register.
// Emission rate is set by the single RAM read port: one payload byte per unstalled cycle.
// Reset (rst_n, synchronous) clears parser, queue and output; the buffer RAM is not cleared.
`default_nettype none

module crc8_frame_deframer #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // receive byte channel
  input  wire logic                        in_valid,
  output      logic                        in_stall,
  input  wire logic [7:0]                  in_rx_byte,
  // result channel
  output      logic                        out_valid,
  input  wire logic                        out_stall,
  output      logic [7:0]                  out_command,
  output      logic [7:0]                  out_payload_byte,
  output      logic [c8dfr_pkg::LEN_W-1:0] out_payload_length,
  output      logic                        out_has_payload,
  output      logic                        out_last,
  // register port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output      logic [31:0]                 prdata,
  output      logic                        pready
);

  // two banks of BUFFER_DEPTH (rounded up to a power of two) bytes each
  localparam int unsigned IW        = $clog2(BUFFER_DEPTH);
  localparam int unsigned MEM_DEPTH = 2 << IW;

  logic [c8dfr_pkg::LEN_W-1:0] max_len_r, max_len_nxt;
  logic                        cfg_wr;

  logic             q_push, q_pop, q_empty, q_full;
  c8dfr_pkg::desc_t q_push_desc, q_head;

  logic          ram_we, ram_re;
  logic [IW:0]   ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  // ---------------------------------------------------------------------------
  // Register port: one register, max_frame_length, at byte address 0.
  // A write transaction completes in the access phase.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == c8dfr_pkg::REG_MAX_LEN);

  always_comb begin
    max_len_nxt = cfg_wr ? pwdata[c8dfr_pkg::LEN_W-1:0] : max_len_r;
    prdata      = '0;
    if (paddr[2] == c8dfr_pkg::REG_MAX_LEN) begin
      prdata = {{(32 - c8dfr_pkg::LEN_W){1'b0}}, max_len_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= c8dfr_pkg::MAX_LEN_RESET;
    end else begin
      max_len_r <= max_len_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Front: parse and check frames, fill the current bank.
  // ---------------------------------------------------------------------------
  c8dfr_front #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_stall   (in_stall),
    .max_len    (max_len_r),
    .q_full     (q_full),
    .push       (q_push),
    .push_desc  (q_push_desc),
    .we         (ram_we),
    .waddr      (ram_waddr),
    .wdata      (ram_wdata)
  );

  // ---------------------------------------------------------------------------
  // Descriptor queue: a bank stays owned until its frame's last result issues.
  // ---------------------------------------------------------------------------
  c8dfr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_push_desc),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // ---------------------------------------------------------------------------
  // Payload buffer, banked by the descriptor's bank bit.
  // ---------------------------------------------------------------------------
  c8dfr_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Back: emit results from the head frame.
  // ---------------------------------------------------------------------------
  c8dfr_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (q_head),
    .q_empty            (q_empty),
    .pop                (q_pop),
    .re                 (ram_re),
    .raddr              (ram_raddr),
    .rdata              (ram_rdata),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_command        (out_command),
    .out_payload_byte   (out_payload_byte),
    .out_payload_length (out_payload_length),
    .out_has_payload    (out_has_payload),
    .out_last           (out_last)
  );

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // never push onto a full queue unless it pops in the same cycle (bank would be overwritten)
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full && !q_pop))
    else $error("descriptor pushed onto full queue");

  // never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && q_empty))
    else $error("descriptor popped from empty queue");

  // freeing a descriptor presents that frame's last result next cycle
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_valid && out_last))
    else $error("frame released without last result");

  // command-only frames produce a single, last result
  a_cmd_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_payload) |-> (out_last && out_payload_length == '0))
    else $error("command-only result not marked last");

  // front never writes the bank the back is still reading while both are held
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !q_full)
    else $error("payload written while both banks owned");

endmodule

`default_nettype wire
